// ===== rtl/wilson_score_interval_defines.svh =====
// ----------------------------------------------------------------------------
// Wilson score interval assertion macros
// Shared property templates for the checker of the interval block.
// ----------------------------------------------------------------------------
`ifndef WILSON_SCORE_INTERVAL_DEFINES_SVH
`define WILSON_SCORE_INTERVAL_DEFINES_SVH

// same-cycle implication
`define WSI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WSI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Wilson score interval package
// Fixed formats, register map and pipeline control type.
// ----------------------------------------------------------------------------
`default_nettype none

package wsi_pkg;

    localparam int Z_BITS   = 16;        // z in Q4.12
    localparam int RAD_FRAC = 26;        // radicand fraction bits
    localparam int NUM_FRAC = 25;        // numerator / denominator fraction bits
    localparam int NUM_PAD  = 28;        // extra bits over the count width for bound sums
    localparam logic [Z_BITS-1:0] Z_RESET = 16'd6737;

    localparam logic [0:0] ADDR_Z_VALUE = 1'b0;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic valid;
        logic inval;    // n zero or k above n
        logic neg;      // lower numerator below zero
        logic sat_lo;   // lower bound at or above one
        logic sat_hi;   // upper bound at or above one
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/wsi_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of k*(n-k)*2^26 / n; quotient bits shift into the low word.
// ----------------------------------------------------------------------------
`default_nettype none

module wsi_div_cell
    import wsi_pkg::*;
#(
    parameter int CB = 24,
    parameter int LW = 50
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire t_ctl          i_ctl,
    input  wire logic [CB-1:0] i_rem,
    input  wire logic [LW-1:0] i_low,
    input  wire logic [CB-1:0] i_den,
    input  wire logic [CB-1:0] i_k,
    output t_ctl               o_ctl,
    output logic      [CB-1:0] o_rem,
    output logic      [LW-1:0] o_low,
    output logic      [CB-1:0] o_den,
    output logic      [CB-1:0] o_k
);

    t_ctl          r_ctl;
    logic [CB-1:0] r_rem, n_rem;
    logic [LW-1:0] r_low, n_low;
    logic [CB-1:0] r_den;
    logic [CB-1:0] r_k;
    logic [CB:0]   w_cur;
    logic [CB:0]   w_diff;
    logic          w_ge;

    always_comb begin
        w_cur  = {i_rem, i_low[LW-1]};
        w_diff = w_cur - {1'b0, i_den};
        w_ge   = (w_cur >= {1'b0, i_den});
        n_rem  = w_ge ? w_diff[CB-1:0] : w_cur[CB-1:0];
        n_low  = {i_low[LW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_den <= i_den;
            r_k   <= i_k;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_den = r_den;
    assign o_k   = r_k;

endmodule

`default_nettype wire

// ===== rtl/wsi_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square-root cell
// One restoring digit of floor(sqrt(radicand)); two radicand bits per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wsi_sqrt_cell
    import wsi_pkg::*;
#(
    parameter int CB = 24,
    parameter int SW = 26
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire t_ctl            i_ctl,
    input  wire logic [SW+1:0]   i_rem,
    input  wire logic [SW-1:0]   i_root,
    input  wire logic [2*SW-1:0] i_rad,
    input  wire logic [CB-1:0]   i_k,
    input  wire logic [CB-1:0]   i_n,
    output t_ctl                 o_ctl,
    output logic      [SW+1:0]   o_rem,
    output logic      [SW-1:0]   o_root,
    output logic      [2*SW-1:0] o_rad,
    output logic      [CB-1:0]   o_k,
    output logic      [CB-1:0]   o_n
);

    localparam int RB = 2 * SW;

    t_ctl            r_ctl;
    logic [SW+1:0]   r_rem, n_rem;
    logic [SW-1:0]   r_root, n_root;
    logic [RB-1:0]   r_rad;
    logic [CB-1:0]   r_k;
    logic [CB-1:0]   r_n;
    logic [SW+3:0]   w_cur;
    logic [SW+3:0]   w_trial;
    logic [SW+3:0]   w_diff;
    logic            w_ge;

    always_comb begin
        w_cur   = {i_rem, i_rad[RB-1:RB-2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_diff  = w_cur - w_trial;
        w_ge    = (w_cur >= w_trial);
        n_rem   = w_ge ? w_diff[SW+1:0] : w_cur[SW+1:0];
        n_root  = {i_root[SW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[RB-3:0], 2'b00};
            r_k    <= i_k;
            r_n    <= i_n;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
    assign o_k    = r_k;
    assign o_n    = r_n;

endmodule

`default_nettype wire

// ===== rtl/wsi_frac_cell.sv =====
// ----------------------------------------------------------------------------
// Fraction divider cell
// One restoring step of both bound divisions, sharing the denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module wsi_frac_cell
    import wsi_pkg::*;
#(
    parameter int W  = 52,
    parameter int FB = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire t_ctl          i_ctl,
    input  wire logic [W-1:0]  i_rlo,
    input  wire logic [W-1:0]  i_rhi,
    input  wire logic [FB-1:0] i_qlo,
    input  wire logic [FB-1:0] i_qhi,
    input  wire logic [W-1:0]  i_den,
    output t_ctl               o_ctl,
    output logic      [W-1:0]  o_rlo,
    output logic      [W-1:0]  o_rhi,
    output logic      [FB-1:0] o_qlo,
    output logic      [FB-1:0] o_qhi,
    output logic      [W-1:0]  o_den
);

    t_ctl          r_ctl;
    logic [W-1:0]  r_rlo, n_rlo;
    logic [W-1:0]  r_rhi, n_rhi;
    logic [FB-1:0] r_qlo, r_qhi;
    logic [W-1:0]  r_den;
    logic [W:0]    w_tlo, w_thi, w_dlo, w_dhi;
    logic          w_gelo, w_gehi;

    always_comb begin
        w_tlo  = {i_rlo, 1'b0};
        w_thi  = {i_rhi, 1'b0};
        w_dlo  = w_tlo - {1'b0, i_den};
        w_dhi  = w_thi - {1'b0, i_den};
        w_gelo = (w_tlo >= {1'b0, i_den});
        w_gehi = (w_thi >= {1'b0, i_den});
        n_rlo  = w_gelo ? w_dlo[W-1:0] : w_tlo[W-1:0];
        n_rhi  = w_gehi ? w_dhi[W-1:0] : w_thi[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rlo <= n_rlo;
            r_rhi <= n_rhi;
            r_qlo <= {i_qlo[FB-2:0], w_gelo};
            r_qhi <= {i_qhi[FB-2:0], w_gehi};
            r_den <= i_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rlo = r_rlo;
    assign o_rhi = r_rhi;
    assign o_qlo = r_qlo;
    assign o_qhi = r_qhi;
    assign o_den = r_den;

endmodule

`default_nettype wire

// ===== rtl/wilson_score_interval.sv =====
// ----------------------------------------------------------------------------
// Wilson score interval
// Lower and upper Wilson score bounds in Q1.16 from a success/trial count pair.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake               | payload
//  s_axis    | in  | tvalid / tready         | tdata: successes, trials
//  m_axis    | out | tvalid / tready         | tdata: lower, upper; tuser: status
//  apb       | in  | psel/penable/pwrite     | paddr 0: z_value (Q4.12)
//
//  One pair accepted per cycle unless the output stalls; register stages are
//  (COUNT_BITS+26) div cells, (COUNT_BITS+28)/2 sqrt cells, FRAC_BITS frac
//  cells and six fixed stages.
//  The chain lengths come from the divider, square-root and fraction cell rows.
//  The whole chain holds while a result waits in the output register.
//  Synchronous active-low reset clears all valid flags and loads z = 6737.
// ----------------------------------------------------------------------------
`default_nettype none

module wilson_score_interval
    import wsi_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // successes, trials
    input  wire logic [((2*COUNT_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // lower_bound, upper_bound
    output logic      [((2*(FRAC_BITS+1)+7)/8)*8-1:0]   m_axis_tdata,
    // status
    output logic                                        m_axis_tuser,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [0:0]                             paddr,
    input  wire logic [31:0]                            pwdata,
    output logic      [31:0]                            prdata,
    output logic                                        pready
);

    localparam int CB    = COUNT_BITS;
    localparam int FB    = FRAC_BITS;
    localparam int LW    = CB + RAD_FRAC;
    localparam int RW    = CB + RAD_FRAC + 1;
    localparam int SW    = (RW + 1) / 2;
    localparam int RB    = 2 * SW;
    localparam int W     = CB + NUM_PAD;
    localparam int ZZW   = 2 * Z_BITS;
    localparam int SBW   = Z_BITS + SW;
    localparam int OUT_W = ((2*(FB+1)+7)/8)*8;

    logic w_en;

    // ---------------- configuration ----------------
    logic [Z_BITS-1:0] r_z;
    logic [ZZW-1:0]    r_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z <= Z_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_Z_VALUE)) begin
            r_z <= pwdata[Z_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_zz <= ZZW'(r_z) * ZZW'(r_z);
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_Z_VALUE) ? {{(32-Z_BITS){1'b0}}, r_z} : 32'd0;

    // ---------------- input stage ----------------
    t_ctl          r0_ctl, n0_ctl;
    logic [CB-1:0] r0_k, r0_n;

    always_comb begin
        n0_ctl        = '0;
        n0_ctl.valid  = s_axis_tvalid;
        n0_ctl.inval  = (s_axis_tdata[2*CB-1:CB] == '0) ||
                        (s_axis_tdata[CB-1:0] > s_axis_tdata[2*CB-1:CB]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
        end else if (w_en) begin
            r0_ctl <= n0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_k <= s_axis_tdata[CB-1:0];
            r0_n <= s_axis_tdata[2*CB-1:CB];
        end
    end

    // ---------------- k*(n-k) ----------------
    t_ctl            r1_ctl;
    logic [2*CB-1:0] r1_prod;
    logic [CB-1:0]   r1_k, r1_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (w_en) begin
            r1_ctl <= r0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_prod <= (2*CB)'(r0_k) * (2*CB)'(r0_n - r0_k);
            r1_k    <= r0_k;
            r1_n    <= r0_n;
        end
    end

    // ---------------- divider row ----------------
    t_ctl          w_dctl [0:LW];
    logic [CB-1:0] w_drem [0:LW];
    logic [LW-1:0] w_dlow [0:LW];
    logic [CB-1:0] w_dden [0:LW];
    logic [CB-1:0] w_dk   [0:LW];

    assign w_dctl[0] = r1_ctl;
    assign w_drem[0] = r1_prod[2*CB-1:CB];
    assign w_dlow[0] = {r1_prod[CB-1:0], {RAD_FRAC{1'b0}}};
    assign w_dden[0] = r1_n;
    assign w_dk[0]   = r1_k;

    for (genvar gi = 0; gi < LW; gi++) begin : g_div
        wsi_div_cell #(.CB(CB), .LW(LW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_dctl[gi]),
            .i_rem   (w_drem[gi]),
            .i_low   (w_dlow[gi]),
            .i_den   (w_dden[gi]),
            .i_k     (w_dk[gi]),
            .o_ctl   (w_dctl[gi+1]),
            .o_rem   (w_drem[gi+1]),
            .o_low   (w_dlow[gi+1]),
            .o_den   (w_dden[gi+1]),
            .o_k     (w_dk[gi+1])
        );
    end

    // ---------------- radicand ----------------
    t_ctl          r2_ctl;
    logic [RW-1:0] r2_rad;
    logic [CB-1:0] r2_k, r2_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (w_en) begin
            r2_ctl <= w_dctl[LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_rad <= RW'(w_dlow[LW]) + RW'(r_zz);
            r2_k   <= w_dk[LW];
            r2_n   <= w_dden[LW];
        end
    end

    // ---------------- square-root row ----------------
    t_ctl          w_sctl  [0:SW];
    logic [SW+1:0] w_srem  [0:SW];
    logic [SW-1:0] w_sroot [0:SW];
    logic [RB-1:0] w_srad  [0:SW];
    logic [CB-1:0] w_sk    [0:SW];
    logic [CB-1:0] w_sn    [0:SW];

    assign w_sctl[0]  = r2_ctl;
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srad[0]  = RB'(r2_rad);
    assign w_sk[0]    = r2_k;
    assign w_sn[0]    = r2_n;

    for (genvar gj = 0; gj < SW; gj++) begin : g_sqrt
        wsi_sqrt_cell #(.CB(CB), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_sctl[gj]),
            .i_rem   (w_srem[gj]),
            .i_root  (w_sroot[gj]),
            .i_rad   (w_srad[gj]),
            .i_k     (w_sk[gj]),
            .i_n     (w_sn[gj]),
            .o_ctl   (w_sctl[gj+1]),
            .o_rem   (w_srem[gj+1]),
            .o_root  (w_sroot[gj+1]),
            .o_rad   (w_srad[gj+1]),
            .o_k     (w_sk[gj+1]),
            .o_n     (w_sn[gj+1])
        );
    end

    // ---------------- z*sqrt, numerator, denominator ----------------
    t_ctl           r3_ctl;
    logic [SBW-1:0] r3_s;
    logic [W-1:0]   r3_num, r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (w_en) begin
            r3_ctl <= w_sctl[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_s   <= SBW'(r_z) * SBW'(w_sroot[SW]);
            r3_num <= (W'(w_sk[SW]) << NUM_FRAC) + W'(r_zz);
            r3_den <= (W'(w_sn[SW]) << NUM_FRAC) + (W'(r_zz) << 1);
        end
    end

    // ---------------- bound numerators ----------------
    t_ctl         r4_ctl, n4_ctl;
    logic [W-1:0] r4_xlo, r4_xhi, r4_den;
    logic [W-1:0] w_xlo, w_xhi;

    always_comb begin
        w_xlo         = r3_num - W'(r3_s);
        w_xhi         = r3_num + W'(r3_s);
        n4_ctl        = r3_ctl;
        n4_ctl.neg    = (W'(r3_s) > r3_num);
        n4_ctl.sat_lo = (w_xlo >= r3_den);
        n4_ctl.sat_hi = (w_xhi >= r3_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (w_en) begin
            r4_ctl <= n4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_xlo <= w_xlo;
            r4_xhi <= w_xhi;
            r4_den <= r3_den;
        end
    end

    // ---------------- fraction row ----------------
    t_ctl          w_fctl [0:FB];
    logic [W-1:0]  w_frlo [0:FB];
    logic [W-1:0]  w_frhi [0:FB];
    logic [FB-1:0] w_fqlo [0:FB];
    logic [FB-1:0] w_fqhi [0:FB];
    logic [W-1:0]  w_fden [0:FB];

    assign w_fctl[0] = r4_ctl;
    assign w_frlo[0] = r4_xlo;
    assign w_frhi[0] = r4_xhi;
    assign w_fqlo[0] = '0;
    assign w_fqhi[0] = '0;
    assign w_fden[0] = r4_den;

    for (genvar gf = 0; gf < FB; gf++) begin : g_frac
        wsi_frac_cell #(.W(W), .FB(FB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_fctl[gf]),
            .i_rlo   (w_frlo[gf]),
            .i_rhi   (w_frhi[gf]),
            .i_qlo   (w_fqlo[gf]),
            .i_qhi   (w_fqhi[gf]),
            .i_den   (w_fden[gf]),
            .o_ctl   (w_fctl[gf+1]),
            .o_rlo   (w_frlo[gf+1]),
            .o_rhi   (w_frhi[gf+1]),
            .o_qlo   (w_fqlo[gf+1]),
            .o_qhi   (w_fqhi[gf+1]),
            .o_den   (w_fden[gf+1])
        );
    end

    // ---------------- output register ----------------
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    t_ctl        w_octl;
    logic [FB:0] n_lo, n_hi;
    logic        r_out_valid;
    logic [FB:0] r_lo, r_hi;
    logic        r_status;

    assign w_octl = w_fctl[FB];
    assign w_en   = !r_out_valid || m_axis_tready;

    always_comb begin
        if (w_octl.inval || w_octl.neg) begin
            n_lo = '0;
        end else if (w_octl.sat_lo) begin
            n_lo = ONE;
        end else begin
            n_lo = {1'b0, w_fqlo[FB]};
        end
        if (w_octl.inval) begin
            n_hi = '0;
        end else if (w_octl.sat_hi) begin
            n_hi = ONE;
        end else begin
            n_hi = {1'b0, w_fqhi[FB]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_octl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_status <= w_octl.inval ? STATUS_INVALID : STATUS_OK;
        end
    end

    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_hi, r_lo});
    assign m_axis_tuser  = r_status;

endmodule

`default_nettype wire

// ===== rtl/wsi_checker.sv =====
// ----------------------------------------------------------------------------
// Wilson score interval checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wilson_score_interval_defines.svh"

module wsi_checker #(
    parameter int FRAC_BITS = 16
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [((2*(FRAC_BITS+1)+7)/8)*8-1:0] m_axis_tdata,
    input wire logic                                 m_axis_tuser
);

    logic [FRAC_BITS:0] w_lo, w_hi;

    assign w_lo = m_axis_tdata[FRAC_BITS:0];
    assign w_hi = m_axis_tdata[2*FRAC_BITS+1:FRAC_BITS+1];

    `WSI_ASSERT_NXT(a_rst_clears, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid, "valid after reset")
    `WSI_ASSERT_NXT(a_stall_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `WSI_ASSERT_IMP(a_inval_zero, i_clk, !i_rst_n, m_axis_tvalid && m_axis_tuser, (w_lo == '0) && (w_hi == '0), "invalid result with nonzero bounds")
    `WSI_ASSERT_IMP(a_bound_order, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tuser, (w_lo <= w_hi) && (w_hi <= {1'b1, {FRAC_BITS{1'b0}}}), "bounds out of order or above one")

endmodule

bind wilson_score_interval wsi_checker #(.FRAC_BITS(FRAC_BITS)) u_wsi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
